// File: src/tpic_pkg.sv
package tpic_pkg;

  // Configuration register indexes (byte address is 4 times the index).
  localparam logic [2:0] REG_START_PERCENT    = 3'd0;
  localparam logic [2:0] REG_STOP_PERCENT     = 3'd1;
  localparam logic [2:0] REG_OVERFLOW_PERCENT = 3'd2;
  localparam logic [2:0] REG_AUTO_MODE        = 3'd3;
  localparam logic [2:0] REG_PUMP_ENABLE      = 3'd4;
  localparam logic [2:0] REG_WET_THRESHOLD    = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd6;

  // Event codes reported with each result.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_BUTTON   = 3'd1;
  localparam logic [2:0] EV_DRY      = 3'd2;
  localparam logic [2:0] EV_OVERFLOW = 3'd3;
  localparam logic [2:0] EV_SENSOR   = 3'd4;

  // Manual pump command codes.
  localparam logic [1:0] MAN_OFF = 2'd1;
  localparam logic [1:0] MAN_ON  = 2'd2;

  // Remote stop command codes.
  localparam logic [1:0] REM_SET   = 2'd1;
  localparam logic [1:0] REM_CLEAR = 2'd2;

  // Overflow alert releases this many percent below the overflow level.
  localparam logic [6:0] OVF_HYST_PERCENT = 7'd5;

  // Saturation value of the button stability counter.
  localparam logic [9:0] STABLE_MAX = 10'd1023;

endpackage

// File: src/tank_pump_interlock_controller.sv
// A request accepted into the input register moves on to the result register once that
// register is empty or being drained; the result waits there until taken.
// Throughput: one request per cycle while results are taken; the controller state loop is one pass of
// compares and flag updates between the input register and the result register.
// Reset (rst, synchronous, active high) restores the configuration defaults
// 20/90/95/auto/enabled/2000/50, clears all interlock state and empties both stages.
module tank_pump_interlock_controller (
  input  logic        clk,
  input  logic        rst,
  // Tick request channel.
  input  logic        tick_valid,
  output logic        tick_ready,
  input  logic        button_level,
  input  logic [9:0]  level_tenths,
  input  logic        sensor_ok,
  input  logic [11:0] moisture_level,
  input  logic [1:0]  manual_request,
  input  logic [1:0]  remote_stop_request,
  // Result channel.
  output logic        result_valid,
  input  logic        result_ready,
  output logic        pump_on,
  output logic        pump_changed,
  output logic        stop_active,
  output logic        alert_active,
  output logic [2:0]  event_code,
  // APB-style configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [6:0]  start_percent;
  logic [6:0]  stop_percent;
  logic [6:0]  overflow_percent;
  logic        auto_mode;
  logic        pump_enable;
  logic [11:0] wet_threshold;
  logic [9:0]  debounce_ticks;

  // Interlock state.
  logic        pump_running;
  logic        remote_stop;
  logic        button_latch;
  logic        button_held;
  logic        last_button;
  logic [9:0]  stable_count;
  logic        dry_flag;
  logic        overflow_flag;
  logic        fault_flag;

  // Input register stage.
  logic        s_valid;
  logic        s_btn;
  logic [9:0]  s_level;
  logic        s_sensor_ok;
  logic [11:0] s_moisture;
  logic [1:0]  s_manual;
  logic [1:0]  s_remote;
  logic        s_fire;

  // Next values computed from the staged request and the current state.
  logic        pump_running_next;
  logic        remote_stop_next;
  logic        button_latch_next;
  logic        button_held_next;
  logic [9:0]  stable_count_next;
  logic        dry_flag_next;
  logic        overflow_flag_next;
  logic        fault_flag_next;
  logic [2:0]  event_next;
  logic        stop_next;

  // Level limits in tenths of a percent; 127 * 10 fits in 11 bits.
  logic [10:0] level_ext;
  logic [10:0] start_limit;
  logic [10:0] stop_limit;
  logic [10:0] overflow_limit;
  logic [10:0] release_limit;

  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // The result register may load when it is empty or being drained this cycle.
  assign s_fire     = s_valid && (!result_valid || result_ready);
  assign tick_ready = !s_valid || s_fire;

  // ---------------------------------------------------------------------------
  // Configuration write and read.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_percent    <= 7'd20;
      stop_percent     <= 7'd90;
      overflow_percent <= 7'd95;
      auto_mode        <= 1'b1;
      pump_enable      <= 1'b1;
      wet_threshold    <= 12'd2000;
      debounce_ticks   <= 10'd50;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        tpic_pkg::REG_START_PERCENT:    start_percent    <= pwdata[6:0];
        tpic_pkg::REG_STOP_PERCENT:     stop_percent     <= pwdata[6:0];
        tpic_pkg::REG_OVERFLOW_PERCENT: overflow_percent <= pwdata[6:0];
        tpic_pkg::REG_AUTO_MODE:        auto_mode        <= pwdata[0];
        tpic_pkg::REG_PUMP_ENABLE:      pump_enable      <= pwdata[0];
        tpic_pkg::REG_WET_THRESHOLD:    wet_threshold    <= pwdata[11:0];
        tpic_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks   <= pwdata[9:0];
        default: begin
          // Addresses past the register list are ignored.
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tpic_pkg::REG_START_PERCENT:    prdata = 32'(start_percent);
      tpic_pkg::REG_STOP_PERCENT:     prdata = 32'(stop_percent);
      tpic_pkg::REG_OVERFLOW_PERCENT: prdata = 32'(overflow_percent);
      tpic_pkg::REG_AUTO_MODE:        prdata = 32'(auto_mode);
      tpic_pkg::REG_PUMP_ENABLE:      prdata = 32'(pump_enable);
      tpic_pkg::REG_WET_THRESHOLD:    prdata = 32'(wet_threshold);
      tpic_pkg::REG_DEBOUNCE_TICKS:   prdata = 32'(debounce_ticks);
      default:                        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. A new request loads whenever the stage is empty or its
  // current request moves on to the result register in the same cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (tick_ready) begin
      s_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      s_btn       <= button_level;
      s_level     <= level_tenths;
      s_sensor_ok <= sensor_ok;
      s_moisture  <= moisture_level;
      s_manual    <= manual_request;
      s_remote    <= remote_stop_request;
    end
  end

  // ---------------------------------------------------------------------------
  // One tick of the interlock, evaluated on the staged request.
  // ---------------------------------------------------------------------------
  assign level_ext      = 11'(s_level);
  assign start_limit    = 11'(start_percent) * 11'd10;
  assign stop_limit     = 11'(stop_percent) * 11'd10;
  assign overflow_limit = 11'(overflow_percent) * 11'd10;
  assign release_limit  = 11'(overflow_percent - tpic_pkg::OVF_HYST_PERCENT) * 11'd10;

  always_comb begin
    pump_running_next  = pump_running;
    remote_stop_next   = remote_stop;
    button_latch_next  = button_latch;
    button_held_next   = button_held;
    dry_flag_next      = dry_flag;
    overflow_flag_next = overflow_flag;
    fault_flag_next    = fault_flag;
    event_next         = tpic_pkg::EV_NONE;

    // The remote command goes first; a clear also drops the button latch.
    if (s_remote == tpic_pkg::REM_SET) begin
      remote_stop_next = 1'b1;
    end else if (s_remote == tpic_pkg::REM_CLEAR) begin
      remote_stop_next  = 1'b0;
      button_latch_next = 1'b0;
    end

    // Button debounce: any change restarts the count, which saturates.
    if (s_btn != last_button) begin
      stable_count_next = 10'd0;
    end else if (stable_count < tpic_pkg::STABLE_MAX) begin
      stable_count_next = stable_count + 10'd1;
    end else begin
      stable_count_next = stable_count;
    end

    if (stable_count_next >= debounce_ticks) begin
      if (!s_btn && !button_held) begin
        button_held_next  = 1'b1;
        button_latch_next = 1'b1;
        pump_running_next = 1'b0;
        event_next        = tpic_pkg::EV_BUTTON;
      end
      if (s_btn) begin
        button_held_next = 1'b0;
      end
    end

    // Protection checks in priority order, then pump control.
    if (remote_stop_next || button_latch_next) begin
      pump_running_next = 1'b0;
    end else if (s_moisture >= wet_threshold) begin
      pump_running_next = 1'b0;
      if (!dry_flag) begin
        event_next    = tpic_pkg::EV_DRY;
        dry_flag_next = 1'b1;
      end
    end else begin
      dry_flag_next = 1'b0;
      if (level_ext >= overflow_limit) begin
        pump_running_next = 1'b0;
        if (!overflow_flag) begin
          event_next         = tpic_pkg::EV_OVERFLOW;
          overflow_flag_next = 1'b1;
        end
      end else begin
        if (overflow_flag && overflow_percent >= tpic_pkg::OVF_HYST_PERCENT &&
            level_ext < release_limit) begin
          overflow_flag_next = 1'b0;
        end

        if (!s_sensor_ok && !fault_flag) begin
          event_next      = tpic_pkg::EV_SENSOR;
          fault_flag_next = 1'b1;
        end else if (s_sensor_ok) begin
          fault_flag_next = 1'b0;
        end

        if (!pump_enable) begin
          pump_running_next = 1'b0;
        end else if (auto_mode) begin
          if (level_ext < start_limit) begin
            pump_running_next = 1'b1;
          end else if (level_ext >= stop_limit) begin
            pump_running_next = 1'b0;
          end
        end else begin
          // The unused manual code leaves the pump as it is, like no request.
          if (s_manual == tpic_pkg::MAN_ON) begin
            pump_running_next = 1'b1;
          end else if (s_manual == tpic_pkg::MAN_OFF) begin
            pump_running_next = 1'b0;
          end
        end
      end
    end

    stop_next = remote_stop_next || button_latch_next;
  end

  // State advances only when the staged request is handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pump_running  <= 1'b0;
      remote_stop   <= 1'b0;
      button_latch  <= 1'b0;
      button_held   <= 1'b0;
      last_button   <= 1'b1;
      stable_count  <= 10'd0;
      dry_flag      <= 1'b0;
      overflow_flag <= 1'b0;
      fault_flag    <= 1'b0;
    end else if (s_fire) begin
      pump_running  <= pump_running_next;
      remote_stop   <= remote_stop_next;
      button_latch  <= button_latch_next;
      button_held   <= button_held_next;
      last_button   <= s_btn;
      stable_count  <= stable_count_next;
      dry_flag      <= dry_flag_next;
      overflow_flag <= overflow_flag_next;
      fault_flag    <= fault_flag_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      pump_on      <= pump_running_next;
      pump_changed <= pump_running_next != pump_running;
      stop_active  <= stop_next;
      alert_active <= stop_next || dry_flag_next || overflow_flag_next || fault_flag_next;
      event_code   <= event_next;
    end
  end

endmodule

// File: src/tpic_checker.sv
module tpic_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       pump_on,
  input logic       pump_changed,
  input logic       stop_active,
  input logic       alert_active,
  input logic [2:0] event_code
);

  // A result waiting for the consumer keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable({pump_on, pump_changed, stop_active, alert_active, event_code}))
    else $error("stalled result changed");

  // An active stop always counts as an alert and keeps the pump off.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && stop_active |-> alert_active && !pump_on)
    else $error("stop active without alert or with pump running");

  // A button stop event latches the stop.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && event_code == tpic_pkg::EV_BUTTON |-> stop_active)
    else $error("button event without stop");

  // Dry run and overflow events force the pump off and raise an alert.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_code == tpic_pkg::EV_DRY || event_code == tpic_pkg::EV_OVERFLOW)
      |-> !pump_on && alert_active)
    else $error("protection event with pump running");

  // Only defined event codes are reported.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> event_code <= tpic_pkg::EV_SENSOR)
    else $error("undefined event code");

endmodule

bind tank_pump_interlock_controller tpic_checker u_tpic_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .pump_on      (pump_on),
  .pump_changed (pump_changed),
  .stop_active  (stop_active),
  .alert_active (alert_active),
  .event_code   (event_code)
);

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the package leaves unnamed: "no command" and the one
  // spare encoding of each two-bit command field.
  localparam logic [1:0] MAN_NONE   = 2'd0;
  localparam logic [1:0] MAN_SPARE  = 2'd3;
  localparam logic [1:0] REM_NONE   = 2'd0;
  localparam logic [1:0] REM_SPARE  = 2'd3;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_PHASE      = 9;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_GAP         = 30;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TIMEOUT_NS      = 3_000_000;

  // Extreme settings, indexed by register index.
  localparam int LOW_SETTING  [7] = '{1, 1, 5, 0, 0, 0, 0};
  localparam int HIGH_SETTING [7] = '{99, 100, 100, 1, 1, 4095, 1000};

  typedef struct packed {
    logic       button;
    logic [9:0] level;
    logic       sensor_ok;
    logic [11:0] moisture;
    logic [1:0] manual;
    logic [1:0] remote;
  } tick_t;

  typedef struct packed {
    logic       pump_on;
    logic       pump_changed;
    logic       stop_active;
    logic       alert_active;
    logic [2:0] event_code;
  } result_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // One line of the directed plan: either a tick request, optionally with its
  // result written out by hand, or a register write.
  typedef struct {
    row_kind_t   kind;
    tick_t       stim;
    logic        fixed;
    result_t     want;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        tick_valid;
  logic        tick_ready;
  logic        button_level;
  logic [9:0]  level_tenths;
  logic        sensor_ok;
  logic [11:0] moisture_level;
  logic [1:0]  manual_request;
  logic [1:0]  remote_stop_request;
  logic        result_valid;
  logic        result_ready;
  logic        pump_on;
  logic        pump_changed;
  logic        stop_active;
  logic        alert_active;
  logic [2:0]  event_code;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tank_pump_interlock_controller u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .tick_valid          (tick_valid),
    .tick_ready          (tick_ready),
    .button_level        (button_level),
    .level_tenths        (level_tenths),
    .sensor_ok           (sensor_ok),
    .moisture_level      (moisture_level),
    .manual_request      (manual_request),
    .remote_stop_request (remote_stop_request),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .pump_on             (pump_on),
    .pump_changed        (pump_changed),
    .stop_active         (stop_active),
    .alert_active        (alert_active),
    .event_code          (event_code),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Shadow of the configuration registers, held masked to their widths.
  logic [31:0] reg_file [7];

  // Shadow of the interlock state.
  logic       pump_run_q;
  logic       remote_hold;
  logic       btn_latched;
  logic       btn_acted;
  logic       btn_prev;
  logic [9:0] btn_stable_cnt;
  logic       dry_seen;
  logic       ovf_seen;
  logic       fault_seen;

  // Results still owed by the block, oldest first.
  result_t awaited_results [$];

  int n_errors;
  int n_ticks;
  int n_results;
  int n_writes;
  int ev_seen [8];

  // Idle pressure on both channels, in percent of cycles.
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_pending;

  // State of the random stimulus walk.
  logic       walk_button;
  int         walk_level;

  plan_row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block stops answering.
  initial begin
    #TIMEOUT_NS;
    $display("Run did not finish within the time limit.");
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    n_errors++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, want %0d", what, got, want));
  endtask

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      tpic_pkg::REG_START_PERCENT,
      tpic_pkg::REG_STOP_PERCENT,
      tpic_pkg::REG_OVERFLOW_PERCENT: return 32'h7F;
      tpic_pkg::REG_AUTO_MODE,
      tpic_pkg::REG_PUMP_ENABLE:      return 32'h1;
      tpic_pkg::REG_WET_THRESHOLD:    return 32'hFFF;
      tpic_pkg::REG_DEBOUNCE_TICKS:   return 32'h3FF;
      default:                        return 32'h0;
    endcase
  endfunction

  // Brings the shadow registers and interlock state to their reset values.
  function automatic void reset_interlock();
    reg_file[tpic_pkg::REG_START_PERCENT]    = 20;
    reg_file[tpic_pkg::REG_STOP_PERCENT]     = 90;
    reg_file[tpic_pkg::REG_OVERFLOW_PERCENT] = 95;
    reg_file[tpic_pkg::REG_AUTO_MODE]        = 1;
    reg_file[tpic_pkg::REG_PUMP_ENABLE]      = 1;
    reg_file[tpic_pkg::REG_WET_THRESHOLD]    = 2000;
    reg_file[tpic_pkg::REG_DEBOUNCE_TICKS]   = 50;
    pump_run_q     = 1'b0;
    remote_hold    = 1'b0;
    btn_latched    = 1'b0;
    btn_acted      = 1'b0;
    btn_prev       = 1'b1;
    btn_stable_cnt = '0;
    dry_seen       = 1'b0;
    ovf_seen       = 1'b0;
    fault_seen     = 1'b0;
  endfunction

  // Advances the shadow interlock by one tick and returns what the block
  // must report for it. Only one event can be raised per tick because each
  // protection branch ends the chain once it has acted.
  function automatic result_t advance_interlock(input tick_t t);
    result_t    r;
    logic       was_running;
    logic [2:0] ev;
    int         lvl;
    int         ovf;
    logic       stopped;

    was_running = pump_run_q;
    ev          = tpic_pkg::EV_NONE;
    lvl         = int'(t.level);
    ovf         = reg_file[tpic_pkg::REG_OVERFLOW_PERCENT];

    // The remote command comes first; a clear also drops the button latch.
    if (t.remote == tpic_pkg::REM_SET) begin
      remote_hold = 1'b1;
    end else if (t.remote == tpic_pkg::REM_CLEAR) begin
      remote_hold = 1'b0;
      btn_latched = 1'b0;
    end

    // Debounce: any change restarts the count, which saturates at the top.
    if (t.button != btn_prev)
      btn_stable_cnt = '0;
    else if (btn_stable_cnt != tpic_pkg::STABLE_MAX)
      btn_stable_cnt++;
    btn_prev = t.button;
    if (btn_stable_cnt >= reg_file[tpic_pkg::REG_DEBOUNCE_TICKS]) begin
      if (!t.button && !btn_acted) begin
        btn_acted   = 1'b1;
        btn_latched = 1'b1;
        pump_run_q  = 1'b0;
        ev          = tpic_pkg::EV_BUTTON;
      end
      if (t.button)
        btn_acted = 1'b0;
    end

    if (remote_hold || btn_latched) begin
      pump_run_q = 1'b0;
    end else if (t.moisture >= reg_file[tpic_pkg::REG_WET_THRESHOLD]) begin
      pump_run_q = 1'b0;
      if (!dry_seen) begin
        ev       = tpic_pkg::EV_DRY;
        dry_seen = 1'b1;
      end
    end else begin
      dry_seen = 1'b0;
      if (lvl >= ovf * 10) begin
        pump_run_q = 1'b0;
        if (!ovf_seen) begin
          ev       = tpic_pkg::EV_OVERFLOW;
          ovf_seen = 1'b1;
        end
      end else begin
        // Overflow releases only well below its level, and never when the
        // overflow setting is lower than the hysteresis band.
        if (ovf_seen && ovf >= int'(tpic_pkg::OVF_HYST_PERCENT) &&
            lvl < (ovf - int'(tpic_pkg::OVF_HYST_PERCENT)) * 10)
          ovf_seen = 1'b0;
        if (!t.sensor_ok && !fault_seen) begin
          ev         = tpic_pkg::EV_SENSOR;
          fault_seen = 1'b1;
        end else if (t.sensor_ok) begin
          fault_seen = 1'b0;
        end
        if (!reg_file[tpic_pkg::REG_PUMP_ENABLE][0]) begin
          pump_run_q = 1'b0;
        end else if (reg_file[tpic_pkg::REG_AUTO_MODE][0]) begin
          if (lvl < int'(reg_file[tpic_pkg::REG_START_PERCENT]) * 10)
            pump_run_q = 1'b1;
          else if (lvl >= int'(reg_file[tpic_pkg::REG_STOP_PERCENT]) * 10)
            pump_run_q = 1'b0;
        end else if (t.manual == tpic_pkg::MAN_ON) begin
          pump_run_q = 1'b1;
        end else if (t.manual == tpic_pkg::MAN_OFF) begin
          pump_run_q = 1'b0;
        end
      end
    end

    stopped        = remote_hold || btn_latched;
    r.pump_on      = pump_run_q;
    r.pump_changed = pump_run_q != was_running;
    r.stop_active  = stopped;
    r.alert_active = stopped || dry_seen || ovf_seen || fault_seen;
    r.event_code   = ev;
    return r;
  endfunction

  function automatic tick_t make_tick(input logic b, input int lvl, input logic ok,
                                      input int moist, input logic [1:0] man,
                                      input logic [1:0] rem);
    tick_t t;
    t.button    = b;
    t.level     = lvl[9:0];
    t.sensor_ok = ok;
    t.moisture  = moist[11:0];
    t.manual    = man;
    t.remote    = rem;
    return t;
  endfunction

  function automatic plan_row_t free_tick(input tick_t t);
    plan_row_t row;
    row.kind    = ROW_TICK;
    row.stim    = t;
    row.fixed   = 1'b0;
    row.want    = '0;
    row.reg_idx = '0;
    row.reg_val = '0;
    return row;
  endfunction

  function automatic plan_row_t fixed_tick(input tick_t t, input result_t want);
    plan_row_t row;
    row       = free_tick(t);
    row.fixed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] idx, input int val);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.stim    = '0;
    row.fixed   = 1'b0;
    row.want    = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Picks a register value: the first two phases use the low and high
  // extremes, later phases mostly typical values with an odd extreme.
  function automatic logic [31:0] pick_setting(input logic [2:0] idx, input int phase);
    int r;
    r = $urandom_range(9);
    if (phase == 0) return LOW_SETTING[idx];
    if (phase == 1) return HIGH_SETTING[idx];
    case (idx)
      tpic_pkg::REG_START_PERCENT:
        return (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(60, 5);
      tpic_pkg::REG_STOP_PERCENT:
        return (r == 0) ? 127 : (r == 1) ? 0 : $urandom_range(100, 40);
      tpic_pkg::REG_OVERFLOW_PERCENT:
        return (r == 0) ? 127 : (r == 1) ? $urandom_range(4) : $urandom_range(100, 45);
      tpic_pkg::REG_AUTO_MODE:
        return $urandom_range(1);
      tpic_pkg::REG_PUMP_ENABLE:
        return (r < 8) ? 1 : 0;
      tpic_pkg::REG_WET_THRESHOLD:
        return (r == 0) ? 4095 : (r == 1) ? $urandom_range(200) : $urandom_range(4095, 1000);
      tpic_pkg::REG_DEBOUNCE_TICKS:
        return (r == 0) ? $urandom_range(1023, 900) : $urandom_range(6);
      default:
        return 0;
    endcase
  endfunction

  // Random ticks follow a slowly moving tank level and a button that stays put
  // for runs of ticks, so that hysteresis and debounce are actually crossed.
  // The cistern is mostly wet, since a dry cistern masks everything after it.
  function automatic tick_t random_tick();
    tick_t t;
    int    thr;
    int    sel;
    if ($urandom_range(5) == 0)
      walk_button = ~walk_button;
    if ($urandom_range(9) == 0)
      walk_level = int'($urandom_range(1023));
    else
      walk_level += int'($urandom_range(80)) - 40;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > 1023) walk_level = 1023;
    thr = reg_file[tpic_pkg::REG_WET_THRESHOLD];
    t.button    = walk_button;
    t.level     = walk_level[9:0];
    t.sensor_ok = ($urandom_range(9) != 0);
    if (thr > 0 && $urandom_range(6) != 0)
      t.moisture = 12'($urandom_range(thr - 1));
    else
      t.moisture = 12'($urandom_range(4095));
    t.manual = 2'($urandom_range(3));
    sel = $urandom_range(59);
    case (sel)
      0:       t.remote = tpic_pkg::REM_SET;
      1, 2:    t.remote = tpic_pkg::REM_CLEAR;
      3:       t.remote = REM_SPARE;
      default: t.remote = REM_NONE;
    endcase
    return t;
  endfunction

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 19;
        recv_idle_pct = 74;
      end
      1: begin
        send_idle_pct = 74;
        recv_idle_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Offers one tick request, after a random gap, and holds it steady until the
  // block takes it. The expected result is recorded at the accepting edge.
  task automatic send_tick(input tick_t t, input logic fixed, input result_t want);
    int      gap;
    result_t predicted;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_valid          <= 1'b1;
    button_level        <= t.button;
    level_tenths        <= t.level;
    sensor_ok           <= t.sensor_ok;
    moisture_level      <= t.moisture;
    manual_request      <= t.manual;
    remote_stop_request <= t.remote;
    @(posedge clk);
    while (!tick_ready)
      @(posedge clk);
    predicted = advance_interlock(t);
    awaited_results.push_back(fixed ? want : predicted);
    n_ticks++;
  endtask

  // Writes one register once the block has gone quiet, then reads it back.
  // Every tick yields a result, so an empty queue plus the pipeline depth
  // means nothing is left inside the block.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    tick_valid <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    reg_file[idx] = value & reg_mask(idx);
    n_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    check_field($sformatf("readback of register %0d", idx), prdata, reg_file[idx]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: takes results at a random rate, and once per run refuses them
  // for a long counted stretch so that the block backs up into its input.
  initial begin
    int held;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        result_ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_off_pending = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: every accepted result is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid && result_ready) begin
      got = '{pump_on, pump_changed, stop_active, alert_active, event_code};
      n_results++;
      ev_seen[event_code]++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting", n_results));
      end else begin
        want = awaited_results.pop_front();
        check_field($sformatf("result %0d pump_on", n_results), got.pump_on, want.pump_on);
        check_field($sformatf("result %0d pump_changed", n_results),
                    got.pump_changed, want.pump_changed);
        check_field($sformatf("result %0d stop_active", n_results),
                    got.stop_active, want.stop_active);
        check_field($sformatf("result %0d alert_active", n_results),
                    got.alert_active, want.alert_active);
        check_field($sformatf("result %0d event_code", n_results),
                    got.event_code, want.event_code);
      end
    end
  end

  initial begin
    // Every input is known from time zero, with reset held high.
    rst                 = 1'b1;
    tick_valid          = 1'b0;
    button_level        = 1'b1;
    level_tenths        = '0;
    sensor_ok           = 1'b1;
    moisture_level      = '0;
    manual_request      = MAN_NONE;
    remote_stop_request = REM_NONE;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    hold_off_pending    = 1'b0;
    n_errors            = 0;
    n_ticks             = 0;
    n_results           = 0;
    n_writes            = 0;
    foreach (ev_seen[i]) ev_seen[i] = 0;
    walk_button         = 1'b1;
    walk_level          = 500;
    reset_interlock();
    set_idle_mode(0);

    // Directed plan under the reset settings. The first rows walk through
    // auto control, overflow with its hysteresis band, the dry cistern and a
    // sensor fault; the debounce count is still far below its default, so
    // the button plays no part yet.
    plan.push_back(fixed_tick(make_tick(1'b1, 500, 1'b1, 0, MAN_NONE, REM_NONE),
                              result_t'{1'b0, 1'b0, 1'b0, 1'b0, tpic_pkg::EV_NONE}));
    plan.push_back(fixed_tick(make_tick(1'b1, 0, 1'b1, 0, MAN_NONE, REM_NONE),
                              result_t'{1'b1, 1'b1, 1'b0, 1'b0, tpic_pkg::EV_NONE}));
    plan.push_back(fixed_tick(make_tick(1'b1, 1000, 1'b1, 0, MAN_NONE, REM_NONE),
                              result_t'{1'b0, 1'b1, 1'b0, 1'b1, tpic_pkg::EV_OVERFLOW}));
    // Level beyond full scale still compares as given.
    plan.push_back(free_tick(make_tick(1'b1, 1023, 1'b1, 0, MAN_NONE, REM_NONE)));
    // Inside the hysteresis band the overflow alert must hold.
    plan.push_back(free_tick(make_tick(1'b1, 920, 1'b1, 0, MAN_NONE, REM_NONE)));
    plan.push_back(free_tick(make_tick(1'b1, 800, 1'b1, 0, MAN_NONE, REM_NONE)));
    plan.push_back(fixed_tick(make_tick(1'b1, 500, 1'b1, 4095, MAN_NONE, REM_NONE),
                              result_t'{1'b0, 1'b0, 1'b0, 1'b1, tpic_pkg::EV_DRY}));
    // A reading equal to the threshold still counts as dry.
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 2000, MAN_NONE, REM_NONE)));
    plan.push_back(fixed_tick(make_tick(1'b1, 100, 1'b0, 1999, MAN_NONE, REM_NONE),
                              result_t'{1'b1, 1'b1, 1'b0, 1'b1, tpic_pkg::EV_SENSOR}));
    plan.push_back(free_tick(make_tick(1'b1, 100, 1'b0, 0, MAN_NONE, tpic_pkg::REM_SET)));
    // The spare remote code must leave the stop in place.
    plan.push_back(free_tick(make_tick(1'b1, 100, 1'b0, 0, MAN_NONE, REM_SPARE)));
    plan.push_back(free_tick(make_tick(1'b1, 100, 1'b1, 0, MAN_NONE, tpic_pkg::REM_CLEAR)));

    // Manual control with the button acted on at once.
    plan.push_back(reg_row(tpic_pkg::REG_AUTO_MODE, 0));
    plan.push_back(reg_row(tpic_pkg::REG_DEBOUNCE_TICKS, 0));
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, tpic_pkg::MAN_OFF, REM_NONE)));
    // The spare manual code behaves as no command.
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, MAN_SPARE, REM_NONE)));
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, tpic_pkg::MAN_ON, REM_NONE)));
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, MAN_NONE, REM_NONE)));
    plan.push_back(fixed_tick(make_tick(1'b0, 500, 1'b1, 0, MAN_NONE, REM_NONE),
                              result_t'{1'b0, 1'b1, 1'b1, 1'b1, tpic_pkg::EV_BUTTON}));
    plan.push_back(free_tick(make_tick(1'b0, 500, 1'b1, 0, MAN_NONE, REM_NONE)));
    // Clearing while the button is still held must not latch it again.
    plan.push_back(free_tick(make_tick(1'b0, 500, 1'b1, 0, tpic_pkg::MAN_ON,
                                       tpic_pkg::REM_CLEAR)));
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, MAN_NONE, REM_NONE)));
    plan.push_back(reg_row(tpic_pkg::REG_PUMP_ENABLE, 0));
    plan.push_back(free_tick(make_tick(1'b1, 500, 1'b1, 0, tpic_pkg::MAN_ON, REM_NONE)));

    // An overflow setting below the hysteresis band never releases its alert.
    plan.push_back(reg_row(tpic_pkg::REG_PUMP_ENABLE, 1));
    plan.push_back(reg_row(tpic_pkg::REG_OVERFLOW_PERCENT, 3));
    plan.push_back(free_tick(make_tick(1'b1, 40, 1'b1, 0, MAN_NONE, REM_NONE)));
    plan.push_back(free_tick(make_tick(1'b1, 0, 1'b1, 0, MAN_NONE, REM_NONE)));
    // A zero threshold means the cistern is always dry.
    plan.push_back(reg_row(tpic_pkg::REG_WET_THRESHOLD, 0));
    plan.push_back(free_tick(make_tick(1'b1, 0, 1'b1, 0, MAN_NONE, REM_NONE)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        write_register(plan[i].reg_idx, plan[i].reg_val);
      else
        send_tick(plan[i].stim, plan[i].fixed, plan[i].want);
    end

    // Random phases: a fresh setting for every register, then a burst of
    // ticks. Idle pressure moves from a slow receiver to a slow sender to
    // none, and one phase carries the long receiver hold-off.
    for (int p = 0; p < PHASES; p++) begin
      for (int r = tpic_pkg::REG_START_PERCENT; r <= tpic_pkg::REG_DEBOUNCE_TICKS; r++)
        write_register(r[2:0], pick_setting(r[2:0], p));
      set_idle_mode(p / 4);
      if (p == HOLD_PHASE)
        hold_off_pending = 1'b1;
      repeat (ITEMS_PER_PHASE)
        send_tick(random_tick(), 1'b0, '0);
    end

    @(negedge clk);
    tick_valid <= 1'b0;
    while (awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Ran %0d tick requests and %0d register writes; %0d results checked.",
             n_ticks, n_writes, n_results);
    $display("Events seen: button %0d, dry %0d, overflow %0d, sensor %0d; %0d mismatches.",
             ev_seen[tpic_pkg::EV_BUTTON], ev_seen[tpic_pkg::EV_DRY],
             ev_seen[tpic_pkg::EV_OVERFLOW], ev_seen[tpic_pkg::EV_SENSOR], n_errors);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
